// ===== src/motor_duty_boost_sequencer_defines.svh =====
// Assertion macros used by the motor duty boost sequencer core.
`ifndef MOTOR_DUTY_BOOST_SEQUENCER_DEFINES_SVH
`define MOTOR_DUTY_BOOST_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define MDBS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mdbs: same-cycle check failed");

// Next-cycle implication, checked on clk, off while arst_n is low.
`define MDBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mdbs: next-cycle check failed");

`endif

// ===== src/mdbs_pkg.sv =====
// Package: types, constants and boost table for the motor duty boost sequencer.
package mdbs_pkg;

	localparam int TABLE_ROWS_DEF = 5;

	localparam int DUTY_W  = 10;
	localparam int DRIVE_W = 11;
	localparam int TICKS_W = 7;
	localparam int LEN_W   = 6;
	localparam int ROW_W   = 3;
	localparam int PHASE_W = 2;

	// sequence phase codes
	localparam logic [PHASE_W-1:0] PHASE_IDLE   = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_CHARGE = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_BOOST  = 2'd2;
	localparam logic [PHASE_W-1:0] PHASE_SETTLE = 2'd3;

	// input word kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	typedef struct packed {
		logic [DUTY_W:0]           limit;
		logic [LEN_W-1:0]          charge_len;
		logic signed [DRIVE_W-1:0] boost_val;
		logic [LEN_W-1:0]          boost_len;
		logic [LEN_W-1:0]          settle_len;
	} boost_row_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  pwm_duty;
		logic               dir_a;
		logic               dir_b;
		logic [PHASE_W-1:0] phase;
		logic               accepted;
	} result_t;

	localparam boost_row_t DOWN_ROW = '{11'd1024, 6'd0, -11'sd1023, 6'd5, 6'd56};

	function automatic boost_row_t up_row(input logic [ROW_W-1:0] idx);
		boost_row_t r;
		case (idx)
			3'd0:    r = '{11'd603,  6'd0,  11'sd1023, 6'd10, 6'd51};
			3'd1:    r = '{11'd783,  6'd0,  11'sd1023, 6'd20, 6'd41};
			3'd2:    r = '{11'd903,  6'd10, 11'sd1023, 6'd50, 6'd0};
			3'd3:    r = '{11'd963,  6'd10, 11'sd1023, 6'd50, 6'd0};
			default: r = '{11'd1023, 6'd15, 11'sd1023, 6'd20, 6'd25};
		endcase
		return r;
	endfunction

endpackage

// ===== src/mdbs_row_sel.sv =====
// Row picker: first table row whose limit covers the target duty.
module mdbs_row_sel #(
	parameter int TABLE_ROWS = mdbs_pkg::TABLE_ROWS_DEF
) (
	input  logic [mdbs_pkg::DUTY_W-1:0] target_duty,
	output logic [mdbs_pkg::ROW_W-1:0]  row_idx
);
	import mdbs_pkg::*;

	localparam int MAX_ROWS = 1 << ROW_W;

	// scan from the top so the lowest matching row wins; no match keeps the last row
	always_comb begin
		boost_row_t r;
		row_idx = ROW_W'(TABLE_ROWS - 1);
		for (int i = MAX_ROWS - 1; i >= 0; i--) begin
			r = up_row(ROW_W'(i));
			if (i < TABLE_ROWS && {1'b0, target_duty} <= r.limit) begin
				row_idx = ROW_W'(i);
			end
		end
	end

endmodule

// ===== src/mdbs_core.sv =====
// Sequencer core: phase state, tick countdown, drive value and result word.
`include "motor_duty_boost_sequencer_defines.svh"

module mdbs_core #(
	parameter int TABLE_ROWS = mdbs_pkg::TABLE_ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        kind,
	input  logic [mdbs_pkg::DUTY_W-1:0] target_duty,
	output mdbs_pkg::result_t           res
);
	import mdbs_pkg::*;

	logic [DUTY_W-1:0]          last_duty_q, last_duty_d;
	logic [PHASE_W-1:0]         seq_phase_q, seq_phase_d;
	logic [TICKS_W-1:0]         ticks_q, ticks_d;
	logic [ROW_W-1:0]           row_idx_q, row_idx_d;
	logic                       going_down_q, going_down_d;
	logic [DUTY_W-1:0]          pending_q, pending_d;
	logic signed [DRIVE_W-1:0]  drive_q, drive_d;

	logic [ROW_W-1:0]   pick_idx;
	logic               accepted_d;
	logic               cmd_down;
	boost_row_t         cur_row, cmd_row;
	logic [TICKS_W-1:0] ticks_dec;
	logic [DRIVE_W-1:0] drive_neg;

	mdbs_row_sel #(.TABLE_ROWS(TABLE_ROWS)) u_row_sel (
		.target_duty(target_duty),
		.row_idx    (pick_idx)
	);

	assign cmd_down  = !(target_duty > last_duty_q);
	assign cmd_row   = cmd_down ? DOWN_ROW : up_row(pick_idx);
	assign cur_row   = going_down_q ? DOWN_ROW : up_row(row_idx_q);
	assign ticks_dec = (ticks_q != '0) ? ticks_q - TICKS_W'(1) : ticks_q;

	always_comb begin
		last_duty_d  = last_duty_q;
		seq_phase_d  = seq_phase_q;
		ticks_d      = ticks_q;
		row_idx_d    = row_idx_q;
		going_down_d = going_down_q;
		pending_d    = pending_q;
		drive_d      = drive_q;
		accepted_d   = 1'b0;
		if (kind == KIND_CMD) begin
			if (seq_phase_q == PHASE_IDLE) begin
				going_down_d = cmd_down;
				row_idx_d    = cmd_down ? '0 : pick_idx;
				pending_d    = target_duty;
				last_duty_d  = target_duty;
				seq_phase_d  = PHASE_CHARGE;
				ticks_d      = TICKS_W'(cmd_row.charge_len) + TICKS_W'(1);
				if (cmd_row.charge_len != '0) begin
					drive_d = '0;
				end
				accepted_d   = 1'b1;
			end
		end else if (seq_phase_q != PHASE_IDLE) begin
			ticks_d = ticks_dec;
			if (ticks_dec == '0) begin
				unique case (seq_phase_q)
					PHASE_CHARGE: begin
						seq_phase_d = PHASE_BOOST;
						ticks_d     = TICKS_W'(cur_row.boost_len) + TICKS_W'(1);
						if (cur_row.boost_len != '0) begin
							drive_d = cur_row.boost_val;
						end
					end
					PHASE_BOOST: begin
						seq_phase_d = PHASE_SETTLE;
						ticks_d     = TICKS_W'(cur_row.settle_len) + TICKS_W'(1);
						drive_d     = signed'({1'b0, pending_q});
					end
					default: begin
						seq_phase_d = PHASE_IDLE;
					end
				endcase
			end
		end
	end

	// signed drive to magnitude plus direction pins
	assign drive_neg = DRIVE_W'(-drive_d);

	always_comb begin
		if (drive_d[DRIVE_W-1]) begin
			res.pwm_duty = drive_neg[DRIVE_W-1] ? '1 : drive_neg[DUTY_W-1:0];
		end else begin
			res.pwm_duty = drive_d[DUTY_W-1:0];
		end
		res.dir_a    = !drive_d[DRIVE_W-1];
		res.dir_b    = drive_d[DRIVE_W-1];
		res.phase    = seq_phase_d;
		res.accepted = accepted_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_duty_q  <= '0;
			seq_phase_q  <= PHASE_IDLE;
			ticks_q      <= '0;
			row_idx_q    <= '0;
			going_down_q <= 1'b0;
			pending_q    <= '0;
			drive_q      <= '0;
		end else if (fire) begin
			last_duty_q  <= last_duty_d;
			seq_phase_q  <= seq_phase_d;
			ticks_q      <= ticks_d;
			row_idx_q    <= row_idx_d;
			going_down_q <= going_down_d;
			pending_q    <= pending_d;
			drive_q      <= drive_d;
		end
	end

	`MDBS_ASSERT_NOW(a_idle_no_count, seq_phase_q == PHASE_IDLE, ticks_q == '0)
	`MDBS_ASSERT_NOW(a_busy_counting, seq_phase_q != PHASE_IDLE, ticks_q != '0)
	`MDBS_ASSERT_NOW(a_accept_starts_charge, fire && res.accepted, res.phase == PHASE_CHARGE)
	`MDBS_ASSERT_NEXT(a_hold_without_fire, !fire, $stable(seq_phase_q) && $stable(drive_q))

endmodule

// ===== src/motor_duty_boost_sequencer.sv =====
// Top level: motor duty boost sequencer with input register and result register.
//
// Input channel (cmd_valid / cmd_stall): each word is a one-millisecond tick
// (kind = 0) or a new target PWM duty command (kind = 1, target_duty).
// A command taken while idle starts charge, boost and settle phases;
// a command that arrives mid-sequence is dropped (accepted = 0).
// Output channel (res_valid / res_stall): exactly one result word per input
// word, in order: pwm_duty magnitude, dir_a / dir_b direction pins, the
// phase after this word, and the accepted flag.
// Path: each word passes through the input register, then the result register;
// a full, stalled result register holds it in the input register.
// Throughput: one word per cycle while not stalled; the whole state update is
// one pass of compare and count logic between the two registers.
// Stall: when res_stall holds a full result register, the word in the
// input register waits and cmd_stall rises; no word is lost or repeated.
// Reset (arst_n low, asynchronous): idle phase, last duty zero, forward
// drive of zero, both channels empty.
module motor_duty_boost_sequencer #(
	parameter int TABLE_ROWS = mdbs_pkg::TABLE_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic                         kind,
	input  logic [mdbs_pkg::DUTY_W-1:0]  target_duty,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [mdbs_pkg::DUTY_W-1:0]  pwm_duty,
	output logic                         dir_a,
	output logic                         dir_b,
	output logic [mdbs_pkg::PHASE_W-1:0] phase,
	output logic                         accepted
);
	import mdbs_pkg::*;

	// input register
	logic              valid_s1;
	logic              kind_s1;
	logic [DUTY_W-1:0] target_s1;

	// result register
	logic    res_valid_q;
	result_t res_q;
	result_t res_d;

	logic advance;
	logic fire;

	// result register can load when empty or being drained this cycle
	assign advance   = !res_valid_q || !res_stall;
	assign fire      = valid_s1 && advance;
	assign cmd_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			kind_s1   <= kind;
			target_s1 <= target_duty;
		end
	end

	// state lives in the core and moves only on fire
	mdbs_core #(.TABLE_ROWS(TABLE_ROWS)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.kind       (kind_s1),
		.target_duty(target_s1),
		.res        (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign pwm_duty  = res_q.pwm_duty;
	assign dir_a     = res_q.dir_a;
	assign dir_b     = res_q.dir_b;
	assign phase     = res_q.phase;
	assign accepted  = res_q.accepted;

endmodule
